// ===== rtl/tbs_pkg.sv =====
// Shared types, codes and helpers of the two-bone vertex skinning block.
`default_nettype none
package tbs_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef enum logic [1:0] {
		KIND_WORLD  = 2'd0,
		KIND_BIND   = 2'd1,
		KIND_MAP    = 2'd2,
		KIND_VERTEX = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_BOTH = 2'd0,
		STATUS_A    = 2'd1,
		STATUS_B    = 2'd2,
		STATUS_PASS = 2'd3
	} status_t;

	localparam logic [7:0] REG_RIG_COUNT   = 8'd0;
	localparam logic [7:0] REG_WORLD_COUNT = 8'd1;

	typedef struct packed {
		logic [6:0] rig_count;
		logic [7:0] world_count;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic [10:0]        table_address;
		logic signed [31:0] load_value;
		logic [7:0]         bone_a;
		logic [7:0]         bone_b;
		logic [16:0]        weight;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] nrm_x;
		logic signed [31:0] nrm_y;
		logic signed [31:0] nrm_z;
	} item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] nrm_x;
		logic signed [31:0] nrm_y;
		logic signed [31:0] nrm_z;
		status_t            status;
	} res_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sh7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < -64'sh8000_0000) begin
			r = -32'sh8000_0000;
		end else begin
			r = 32'(x);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/tbs_ifs.sv =====
// Channel interfaces: vertex/load input, result output and configuration write.
`default_nettype none
interface tbs_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [10:0]        table_address;
	logic signed [31:0] load_value;
	logic [7:0]         bone_a;
	logic [7:0]         bone_b;
	logic [16:0]        weight_a;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] nrm_x;
	logic signed [31:0] nrm_y;
	logic signed [31:0] nrm_z;
	modport source(output valid, mode, table_address, load_value, bone_a, bone_b,
		weight_a, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, input ready);
	modport sink(input valid, mode, table_address, load_value, bone_a, bone_b,
		weight_a, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, output ready);
endinterface

interface tbs_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_pos_x;
	logic signed [31:0] out_pos_y;
	logic signed [31:0] out_pos_z;
	logic signed [31:0] out_nrm_x;
	logic signed [31:0] out_nrm_y;
	logic signed [31:0] out_nrm_z;
	logic [1:0]         skin_status;
	modport source(output valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x,
		out_nrm_y, out_nrm_z, skin_status, input ready);
	modport sink(input valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x,
		out_nrm_y, out_nrm_z, skin_status, output ready);
endinterface

interface tbs_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tbs_front.sv =====
// Front end: takes input words, classifies them and holds the configuration registers.
`default_nettype none
module tbs_front (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tbs_in_if.sink       vtx_in,
	tbs_cfg_if.sink      cfg,
	output tbs_pkg::item_t push_item,
	output logic         push_valid,
	input  wire logic    push_ready,
	output tbs_pkg::cfg_t cfg_regs
);

	tbs_pkg::cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign cfg_regs  = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == tbs_pkg::REG_RIG_COUNT) begin
				cfg_q.rig_count <= cfg.data[6:0];
			end else if (cfg.index == tbs_pkg::REG_WORLD_COUNT) begin
				cfg_q.world_count <= cfg.data[7:0];
			end
		end
	end

	assign vtx_in.ready = push_ready;
	assign push_valid   = vtx_in.valid;

	always_comb begin
		push_item.kind          = tbs_pkg::kind_t'(vtx_in.mode);
		push_item.table_address = vtx_in.table_address;
		push_item.load_value    = vtx_in.load_value;
		push_item.bone_a        = vtx_in.bone_a;
		push_item.bone_b        = vtx_in.bone_b;
		// clamp an oversized weight to one
		push_item.weight = (vtx_in.weight_a > tbs_pkg::ONE_Q16) ? tbs_pkg::ONE_Q16
			: vtx_in.weight_a;
		push_item.pos_x = vtx_in.pos_x;
		push_item.pos_y = vtx_in.pos_y;
		push_item.pos_z = vtx_in.pos_z;
		push_item.nrm_x = vtx_in.nrm_x;
		push_item.nrm_y = vtx_in.nrm_y;
		push_item.nrm_z = vtx_in.nrm_z;
	end

endmodule
`default_nettype wire

// ===== rtl/tbs_queue.sv =====
// Short word queue between the front end and the back end.
`default_nettype none
module tbs_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tbs_pkg::item_t push_item,
	input  wire logic           push_valid,
	output logic                push_ready,
	output tbs_pkg::item_t      pop_item,
	output logic                pop_valid,
	input  wire logic           pop_ready
);

	localparam int PW = (tbs_pkg::QUEUE_DEPTH > 1) ? $clog2(tbs_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(tbs_pkg::QUEUE_DEPTH + 1);

	tbs_pkg::item_t slot_q [tbs_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic push, pop;

	assign push_ready = (cnt_q != CW'(tbs_pkg::QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = slot_q[rd_q];
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(tbs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(tbs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tbs_back.sv =====
// Back end: bone stores, shared multiply-accumulate sequencer, square root and divider.
`default_nettype none
module tbs_back #(
	parameter int MAX_WORLD_BONES = 128,
	parameter int MAX_RIG_BONES   = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tbs_pkg::item_t pop_item,
	input  wire logic           pop_valid,
	output logic                pop_ready,
	input  wire tbs_pkg::cfg_t  cfg_regs,
	tbs_out_if.source           res_out
);

	localparam int WID_W  = (MAX_WORLD_BONES > 1) ? $clog2(MAX_WORLD_BONES) : 1;
	localparam int RID_W  = (MAX_RIG_BONES > 1) ? $clog2(MAX_RIG_BONES) : 1;
	localparam int WAW    = WID_W + 4;
	localparam int BAW    = RID_W + 4;
	localparam int WDEPTH = MAX_WORLD_BONES * 16;
	localparam int BDEPTH = MAX_RIG_BONES * 16;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_MAP  = 10'b0000000010,
		ST_MAT  = 10'b0000000100,
		ST_XFM  = 10'b0000001000,
		ST_BLD  = 10'b0000010000,
		ST_NRM  = 10'b0000100000,
		ST_NSQ  = 10'b0001000000,
		ST_SQRT = 10'b0010000000,
		ST_DIV  = 10'b0100000000,
		ST_OUT  = 10'b1000000000
	} state_t;

	logic signed [31:0] wmem [WDEPTH];
	logic signed [31:0] bmem [BDEPTH];
	logic [7:0]         mmem [MAX_RIG_BONES];

	state_t state_q;
	logic [1:0] ph_q;
	logic bone_q;
	logic [1:0] c_q, r_q, k_q, j_q;
	logic [2:0] o_q;
	logic [5:0] it_q;
	tbs_pkg::item_t item_q;
	logic valid_a_q, valid_b_q;
	logic [7:0] id_a_q, id_b_q;
	logic [16:0] wa_q, wb_q;
	logic [7:0] map_rd_q;
	logic signed [31:0] w_rd_q, b_rd_q;
	logic signed [63:0] prod_q;
	logic signed [49:0] acc_q;
	logic signed [31:0] m_q [12];
	logic signed [31:0] t_q [6];
	logic signed [33:0] res_q [6];
	logic signed [31:0] opos_q [3];
	logic signed [31:0] nrm_q [3];
	tbs_pkg::status_t status_q;
	logic [63:0] s_q, root_q, bit_q;
	logic [31:0] len_q;
	logic [47:0] num_q, quo_q;
	logic [31:0] rem_q;
	logic ov_q;
	tbs_pkg::res_t out_q;

	logic pop;
	logic [7:0] rb, id;
	logic signed [31:0] pos_v [4];
	logic signed [31:0] nrm_v [4];
	logic signed [31:0] mul_a, mul_b;
	logic signed [47:0] rnd48;
	logic signed [49:0] acc_n;
	logic [1:0] xr;
	logic [3:0] m_idx;
	logic map_ok;
	logic [63:0] s_n, sq_t, root_n;
	logic [32:0] rem_sh;
	logic [31:0] mag;
	logic signed [31:0] qres;

	assign pop_ready = (state_q == ST_IDLE);
	assign pop = pop_valid && pop_ready;

	// stores: loads write from the queue head, reads are registered
	always_ff @(posedge clk) begin
		if (pop && pop_item.kind == tbs_pkg::KIND_WORLD
				&& {2'b0, pop_item.table_address} < 13'(WDEPTH)) begin
			wmem[WAW'(pop_item.table_address)] <= pop_item.load_value;
		end
		if (pop && pop_item.kind == tbs_pkg::KIND_BIND
				&& {2'b0, pop_item.table_address} < 13'(BDEPTH)) begin
			bmem[BAW'(pop_item.table_address)] <= pop_item.load_value;
		end
		if (pop && pop_item.kind == tbs_pkg::KIND_MAP
				&& {1'b0, pop_item.table_address} < 12'(MAX_RIG_BONES)) begin
			mmem[RID_W'(pop_item.table_address)] <= pop_item.load_value[7:0];
		end
		w_rd_q   <= wmem[{id[WID_W-1:0], k_q, r_q}];
		b_rd_q   <= bmem[{rb[RID_W-1:0], c_q, k_q}];
		map_rd_q <= mmem[rb[RID_W-1:0]];
	end

	assign rb = bone_q ? item_q.bone_b : item_q.bone_a;
	assign id = bone_q ? id_b_q : id_a_q;

	assign pos_v[0] = item_q.pos_x;
	assign pos_v[1] = item_q.pos_y;
	assign pos_v[2] = item_q.pos_z;
	assign pos_v[3] = 32'sd65536;   // translation column rides as a multiply by one
	assign nrm_v[0] = item_q.nrm_x;
	assign nrm_v[1] = item_q.nrm_y;
	assign nrm_v[2] = item_q.nrm_z;
	assign nrm_v[3] = '0;

	assign xr    = (o_q < 3'd3) ? o_q[1:0] : 2'(o_q - 3'd3);
	assign m_idx = 4'(j_q) * 4'd3 + 4'(xr);

	always_comb begin
		mul_a = w_rd_q;
		mul_b = b_rd_q;
		unique case (state_q)
			ST_XFM: begin
				mul_a = m_q[m_idx];
				mul_b = (o_q < 3'd3) ? pos_v[j_q] : nrm_v[j_q];
			end
			ST_BLD: begin
				mul_a = t_q[o_q];
				mul_b = $signed({15'b0, (bone_q ? wb_q : wa_q)});
			end
			ST_NSQ: begin
				mul_a = nrm_q[o_q[1:0]];
				mul_b = nrm_q[o_q[1:0]];
			end
			default: begin
				mul_a = w_rd_q;
				mul_b = b_rd_q;
			end
		endcase
	end

	assign rnd48 = 48'((prod_q + 64'sd32768) >>> 16);
	assign acc_n = acc_q + 50'(rnd48);
	assign map_ok = ({1'b0, rb} < {2'b0, cfg_regs.rig_count})
		&& ({1'b0, rb} < 9'(MAX_RIG_BONES))
		&& ({1'b0, map_rd_q} < {1'b0, cfg_regs.world_count})
		&& ({1'b0, map_rd_q} < 9'(MAX_WORLD_BONES));
	assign s_n    = s_q + 64'(prod_q);
	assign sq_t   = root_q + bit_q;
	assign root_n = (s_q >= sq_t) ? ((root_q >> 1) + bit_q) : (root_q >> 1);
	assign rem_sh = {rem_q, num_q[47]};
	assign mag    = nrm_q[o_q[1:0]][31] ? 32'(-nrm_q[o_q[1:0]]) : nrm_q[o_q[1:0]];
	always_comb begin
		if (nrm_q[o_q[1:0]][31]) begin
			qres = (quo_q > 48'h8000_0000) ? -32'sh8000_0000 : 32'(-quo_q);
		end else begin
			qres = (quo_q > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(quo_q);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				item_q <= pop_item;
				for (int i = 0; i < 6; i++) begin
					res_q[i] <= '0;
				end
			end
			ST_MAP: begin
				if (ph_q == 2'd1) begin
					if (!bone_q) begin
						valid_a_q <= map_ok;
						id_a_q    <= map_rd_q;
					end else begin
						valid_b_q <= map_ok;
						id_b_q    <= map_rd_q;
						if (valid_a_q && map_ok) begin
							wa_q <= item_q.weight;
							wb_q <= 17'(tbs_pkg::ONE_Q16 - item_q.weight);
							status_q <= tbs_pkg::STATUS_BOTH;
						end else if (valid_a_q) begin
							wa_q <= tbs_pkg::ONE_Q16;
							wb_q <= '0;
							status_q <= tbs_pkg::STATUS_A;
						end else if (map_ok) begin
							wa_q <= '0;
							wb_q <= tbs_pkg::ONE_Q16;
							status_q <= tbs_pkg::STATUS_B;
						end else begin
							status_q <= tbs_pkg::STATUS_PASS;
							for (int i = 0; i < 3; i++) begin
								opos_q[i] <= pos_v[i];
								nrm_q[i]  <= nrm_v[i];
							end
						end
					end
				end
				acc_q <= '0;
			end
			ST_MAT: begin
				if (ph_q == 2'd1) begin
					prod_q <= mul_a * mul_b;
				end else if (ph_q == 2'd2) begin
					if (k_q == 2'd3) begin
						m_q[4'(c_q) * 4'd3 + 4'(r_q)] <= tbs_pkg::sat32(64'(acc_n));
						acc_q <= '0;
					end else begin
						acc_q <= acc_n;
					end
				end
			end
			ST_XFM: begin
				if (ph_q == 2'd1) begin
					prod_q <= mul_a * mul_b;
				end else begin
					if (j_q == ((o_q < 3'd3) ? 2'd3 : 2'd2)) begin
						t_q[o_q] <= tbs_pkg::sat32(64'(acc_n));
						acc_q <= '0;
					end else begin
						acc_q <= acc_n;
					end
				end
			end
			ST_BLD: begin
				if (ph_q == 2'd1) begin
					prod_q <= mul_a * mul_b;
				end else begin
					res_q[o_q] <= res_q[o_q] + 34'(rnd48);
				end
				acc_q <= '0;
			end
			ST_NRM: begin
				for (int i = 0; i < 3; i++) begin
					opos_q[i] <= tbs_pkg::sat32(64'(res_q[i]));
					nrm_q[i]  <= tbs_pkg::sat32(64'(res_q[i + 3]));
				end
				s_q <= '0;
			end
			ST_NSQ: begin
				if (ph_q == 2'd1) begin
					prod_q <= mul_a * mul_b;
				end else begin
					s_q    <= s_n;
					root_q <= '0;
					bit_q  <= 64'h4000_0000_0000_0000;
				end
			end
			ST_SQRT: begin
				if (s_q >= sq_t) begin
					s_q <= s_q - sq_t;
				end
				root_q <= root_n;
				bit_q  <= bit_q >> 2;
				len_q  <= root_n[31:0];
			end
			ST_DIV: begin
				if (ph_q == 2'd0) begin
					num_q <= {mag, 16'b0};
					rem_q <= '0;
					quo_q <= '0;
				end else if (ph_q == 2'd1) begin
					// one quotient bit per cycle
					if (rem_sh >= {1'b0, len_q}) begin
						rem_q <= 32'(rem_sh - {1'b0, len_q});
						quo_q <= {quo_q[46:0], 1'b1};
					end else begin
						rem_q <= rem_sh[31:0];
						quo_q <= {quo_q[46:0], 1'b0};
					end
					num_q <= {num_q[46:0], 1'b0};
				end else begin
					nrm_q[o_q[1:0]] <= qres;
				end
			end
			ST_OUT: begin
				if (!ov_q || res_out.ready) begin
					out_q.pos_x  <= opos_q[0];
					out_q.pos_y  <= opos_q[1];
					out_q.pos_z  <= opos_q[2];
					out_q.nrm_x  <= nrm_q[0];
					out_q.nrm_y  <= nrm_q[1];
					out_q.nrm_z  <= nrm_q[2];
					out_q.status <= status_q;
				end
			end
			default: begin
				acc_q <= '0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= '0;
			bone_q  <= 1'b0;
			c_q     <= '0;
			r_q     <= '0;
			k_q     <= '0;
			j_q     <= '0;
			o_q     <= '0;
			it_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && res_out.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && pop_item.kind == tbs_pkg::KIND_VERTEX) begin
						state_q <= ST_MAP;
						bone_q  <= 1'b0;
						ph_q    <= 2'd0;
					end
				end
				ST_MAP: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else if (!bone_q) begin
						bone_q <= 1'b1;
						ph_q   <= 2'd0;
					end else begin
						c_q <= '0;
						r_q <= '0;
						k_q <= '0;
						ph_q <= 2'd0;
						if (valid_a_q) begin
							bone_q  <= 1'b0;
							state_q <= ST_MAT;
						end else if (map_ok) begin
							bone_q  <= 1'b1;
							state_q <= ST_MAT;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_MAT: begin
					if (ph_q == 2'd2) begin
						ph_q <= 2'd0;
						if (k_q == 2'd3) begin
							k_q <= '0;
							if (r_q == 2'd2) begin
								r_q <= '0;
								if (c_q == 2'd3) begin
									c_q     <= '0;
									state_q <= ST_XFM;
									o_q     <= '0;
									j_q     <= '0;
									ph_q    <= 2'd1;
								end else begin
									c_q <= c_q + 1'b1;
								end
							end else begin
								r_q <= r_q + 1'b1;
							end
						end else begin
							k_q <= k_q + 1'b1;
						end
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				ST_XFM: begin
					if (ph_q == 2'd1) begin
						ph_q <= 2'd2;
					end else begin
						ph_q <= 2'd1;
						if (j_q == ((o_q < 3'd3) ? 2'd3 : 2'd2)) begin
							j_q <= '0;
							if (o_q == 3'd5) begin
								o_q     <= '0;
								state_q <= ST_BLD;
							end else begin
								o_q <= o_q + 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				ST_BLD: begin
					if (ph_q == 2'd1) begin
						ph_q <= 2'd2;
					end else begin
						ph_q <= 2'd1;
						if (o_q == 3'd5) begin
							o_q <= '0;
							if (!bone_q && valid_b_q) begin
								bone_q  <= 1'b1;
								ph_q    <= 2'd0;
								state_q <= ST_MAT;
							end else begin
								state_q <= ST_NRM;
							end
						end else begin
							o_q <= o_q + 1'b1;
						end
					end
				end
				ST_NRM: begin
					o_q     <= '0;
					ph_q    <= 2'd1;
					state_q <= ST_NSQ;
				end
				ST_NSQ: begin
					if (ph_q == 2'd1) begin
						ph_q <= 2'd2;
					end else begin
						ph_q <= 2'd1;
						if (o_q == 3'd2) begin
							o_q <= '0;
							// a zero normal is left as it is
							state_q <= (s_n == '0) ? ST_OUT : ST_SQRT;
						end else begin
							o_q <= o_q + 1'b1;
						end
					end
				end
				ST_SQRT: begin
					if (bit_q == 64'd1) begin
						state_q <= ST_DIV;
						o_q     <= '0;
						ph_q    <= 2'd0;
					end
				end
				ST_DIV: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
						it_q <= '0;
					end else if (ph_q == 2'd1) begin
						it_q <= it_q + 1'b1;
						if (it_q == 6'd47) begin
							ph_q <= 2'd2;
						end
					end else begin
						ph_q <= 2'd0;
						if (o_q == 3'd2) begin
							o_q     <= '0;
							state_q <= ST_OUT;
						end else begin
							o_q <= o_q + 1'b1;
						end
					end
				end
				ST_OUT: begin
					if (!ov_q || res_out.ready) begin
						ov_q    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_out.valid       = ov_q;
	assign res_out.out_pos_x   = out_q.pos_x;
	assign res_out.out_pos_y   = out_q.pos_y;
	assign res_out.out_pos_z   = out_q.pos_z;
	assign res_out.out_nrm_x   = out_q.nrm_x;
	assign res_out.out_nrm_y   = out_q.nrm_y;
	assign res_out.out_nrm_z   = out_q.nrm_z;
	assign res_out.skin_status = out_q.status;

endmodule
`default_nettype wire

// ===== rtl/two_bone_vertex_skinning_top.sv =====
// Two-bone vertex skinning top level: front end, word queue and compute back end.
// Load words (world matrix element, bind matrix element, bone map entry) give no
// result in the back end. A blended normal of zero skips the square root and divider.
// Every product goes through one shared 32x32 multiplier: each term of the
// world-times-bind product takes a memory read, a multiply and an accumulate, and each
// term of the transform, blend and squared length a multiply and an accumulate; then
// come a 32-step square root and a 48-step divider per normal component. A result that
// waits on the output holds the back end. Stores hold their contents only once written.
// Configuration writes are taken at any cycle; write them only while idle.
`default_nettype none
module two_bone_vertex_skinning_top #(
	parameter int MAX_WORLD_BONES = 128,
	parameter int MAX_RIG_BONES   = 64
) (
	input wire logic  clk,
	input wire logic  arst_n,
	tbs_in_if.sink    vtx_in,
	tbs_cfg_if.sink   cfg,
	tbs_out_if.source res_out
);

	tbs_pkg::item_t push_item, pop_item;
	tbs_pkg::cfg_t  cfg_regs;
	logic push_valid, push_ready, pop_valid, pop_ready;

	tbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.vtx_in     (vtx_in),
		.cfg        (cfg),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.cfg_regs   (cfg_regs)
	);

	tbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_item   (pop_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	tbs_back #(
		.MAX_WORLD_BONES (MAX_WORLD_BONES),
		.MAX_RIG_BONES   (MAX_RIG_BONES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_item  (pop_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.cfg_regs  (cfg_regs),
		.res_out   (res_out)
	);

endmodule
`default_nettype wire
